// ----- sv/stsig_pkg.sv -----
package stsig_pkg;

    localparam logic [1:0] KIND_UPSERT = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_FIND   = 2'd3;

    localparam logic [3:0] MAX_CHANNEL   = 4'd14;
    localparam int         MULTICAST_BIT = 40;
    localparam logic [1:0] LINK_MAX      = 2'd2;
    localparam logic [1:0] LINK_SEARCH   = 2'd0;

    typedef struct packed {
        logic [1:0]         kind;
        logic [47:0]        mac_address;
        logic [47:0]        bssid_in;
        logic               bssid_valid_in;
        logic [1:0]         link_state_in;
        logic [3:0]         channel_in;
        logic signed [7:0]  rssi_in;
        logic [63:0]        seen_time_in;
        logic [5:0]         entry_select;
    } in_t;

    typedef struct packed {
        logic               ok;
        logic [6:0]         entry_index;
        logic [6:0]         entry_count;
        logic [47:0]        mac_out;
        logic [47:0]        bssid_out;
        logic               bssid_valid_out;
        logic [1:0]         link_state_out;
        logic [3:0]         channel_out;
        logic signed [7:0]  rssi_out;
        logic [63:0]        seen_time_out;
        logic [31:0]        frame_count;
        logic [31:0]        revision;
    } out_t;

    typedef struct packed {
        logic [47:0]        mac;
        logic [47:0]        bssid;
        logic               bssid_known;
        logic [1:0]         link;
        logic [3:0]         channel;
        logic signed [7:0]  rssi;
        logic [63:0]        seen;
        logic [31:0]        frames;
    } rec_t;

endpackage

// ----- sv/station_table_sorted_by_signal_core.sv -----
// Channel | Direction | Handshake        | Beat
// in      | input     | in_valid/ready   | stsig_pkg::in_t, one request
// out     | output    | out_valid/ready  | stsig_pkg::out_t, one result
//
// Clear and a rejected upsert go straight to the result; read fetches the selected entry.
// Find scans the table; upsert scans it, shifts the entries between the old and new
// positions, then writes the entry; the memory takes one read and one write a cycle.
// Reset clears count and revision; table contents are unknown until written.
// A finished result waits in the output register; a new request is taken
// meanwhile, and its own result stalls until the register is free.
module station_table_sorted_by_signal_core #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  stsig_pkg::in_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output stsig_pkg::out_t   out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MOVE = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]       state_reg;
    stsig_pkg::in_t   req_reg;
    logic [CW-1:0]    total_reg;
    logic [31:0]      rev_reg;

    logic [CW-1:0]    scan_rd_reg;
    logic             scan_pend_reg;
    logic [CW-1:0]    scan_tag_reg;
    logic [CW-1:0]    ge_cnt_reg;
    logic [CW-1:0]    gt_cnt_reg;
    logic             hit_reg;
    logic [CW-1:0]    hit_idx_reg;
    stsig_pkg::rec_t  hit_rec_reg;
    logic [CW-1:0]    hit_ge_reg;
    logic [CW-1:0]    hit_gt_reg;
    logic [CW-1:0]    old_idx_reg;
    logic [63:0]      old_seen_reg;
    logic [CW-1:0]    old_ge_reg;
    logic [CW-1:0]    old_gt_reg;

    logic [CW-1:0]    q_reg;
    stsig_pkg::rec_t  x_reg;
    logic [CW-1:0]    mv_rd_reg;
    logic [CW-1:0]    mv_left_reg;
    logic             mv_dn_reg;
    logic             mv_pend_reg;
    logic [CW-1:0]    mv_wa_reg;

    logic             res_ok_reg;
    logic             res_rep_reg;
    logic [6:0]       res_idx_reg;
    stsig_pkg::rec_t  res_rec_reg;

    logic             out_valid_reg;
    stsig_pkg::out_t  out_reg;

    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    stsig_pkg::rec_t  mem_wd;
    logic [AW-1:0]    mem_ra;
    stsig_pkg::rec_t  mem_q;

    logic             in_fire;
    logic             req_good;
    logic [1:0]       link_clean;
    logic             d_match;
    logic             d_ge;
    logic             d_gt;
    logic             d_older;
    stsig_pkg::rec_t  merge_rec;
    stsig_pkg::rec_t  new_rec;
    logic [CW-1:0]    sel_p;
    logic [CW-1:0]    sel_q;
    stsig_pkg::rec_t  sel_x;
    logic             sel_append;
    stsig_pkg::out_t  out_build;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign link_clean = (req_reg.link_state_in > stsig_pkg::LINK_MAX) ?
                        stsig_pkg::LINK_SEARCH : req_reg.link_state_in;

    assign req_good = (in_data.mac_address != 48'd0)
                   && !in_data.mac_address[stsig_pkg::MULTICAST_BIT]
                   && (in_data.channel_in != 4'd0)
                   && (in_data.channel_in <= stsig_pkg::MAX_CHANNEL)
                   && (in_data.seen_time_in != 64'd0);

    assign d_match = (mem_q.mac == req_reg.mac_address);
    assign d_ge    = (mem_q.rssi >= req_reg.rssi_in);
    assign d_gt    = (mem_q.rssi > req_reg.rssi_in);
    assign d_older = (scan_tag_reg == '0) || (mem_q.seen < old_seen_reg);

    always_comb
    begin
        merge_rec         = hit_rec_reg;
        merge_rec.link    = (link_clean > hit_rec_reg.link) ? link_clean : hit_rec_reg.link;
        merge_rec.channel = req_reg.channel_in;
        merge_rec.rssi    = req_reg.rssi_in;
        merge_rec.seen    = req_reg.seen_time_in;
        merge_rec.frames  = hit_rec_reg.frames + 32'd1;
        if (req_reg.bssid_valid_in)
        begin
            merge_rec.bssid       = req_reg.bssid_in;
            merge_rec.bssid_known = 1'b1;
        end

        new_rec.mac         = req_reg.mac_address;
        new_rec.bssid       = req_reg.bssid_valid_in ? req_reg.bssid_in : 48'd0;
        new_rec.bssid_known = req_reg.bssid_valid_in;
        new_rec.link        = link_clean;
        new_rec.channel     = req_reg.channel_in;
        new_rec.rssi        = req_reg.rssi_in;
        new_rec.seen        = req_reg.seen_time_in;
        new_rec.frames      = 32'd1;

        sel_append = 1'b0;
        priority if (hit_reg)
        begin
            sel_p = hit_idx_reg;
            sel_q = hit_ge_reg + gt_cnt_reg - hit_gt_reg;
            sel_x = merge_rec;
        end
        else if (total_reg < CAP)
        begin
            sel_p      = total_reg;
            sel_q      = ge_cnt_reg;
            sel_x      = new_rec;
            sel_append = 1'b1;
        end
        else
        begin
            sel_p = old_idx_reg;
            sel_q = old_ge_reg + gt_cnt_reg - old_gt_reg;
            sel_x = new_rec;
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = mv_wa_reg[AW-1:0];
        mem_wd = mem_q;
        unique case (state_reg)
            S_SCAN:  mem_ra = scan_rd_reg[AW-1:0];
            S_MOVE:  mem_ra = mv_rd_reg[AW-1:0];
            default: mem_ra = AW'(in_data.entry_select);
        endcase
        if (state_reg == S_MOVE && mv_pend_reg)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_PUT)
        begin
            mem_we = 1'b1;
            mem_wa = q_reg[AW-1:0];
            mem_wd = x_reg;
        end
    end

    stsig_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_wa),
        .wdata (mem_wd),
        .raddr (mem_ra),
        .rdata (mem_q)
    );

    always_comb
    begin
        out_build             = '0;
        out_build.ok          = res_ok_reg;
        out_build.entry_count = 7'(total_reg);
        out_build.revision    = rev_reg;
        out_build.entry_index = res_rep_reg ? res_idx_reg : 7'(total_reg);
        if (res_rep_reg)
        begin
            out_build.mac_out         = res_rec_reg.mac;
            out_build.bssid_out       = res_rec_reg.bssid;
            out_build.bssid_valid_out = res_rec_reg.bssid_known;
            out_build.link_state_out  = res_rec_reg.link;
            out_build.channel_out     = res_rec_reg.channel;
            out_build.rssi_out        = res_rec_reg.rssi;
            out_build.seen_time_out   = res_rec_reg.seen;
            out_build.frame_count     = res_rec_reg.frames;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            rev_reg       <= '0;
            out_valid_reg <= 1'b0;
            scan_pend_reg <= 1'b0;
            mv_pend_reg   <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FIN && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        req_reg       <= in_data;
                        scan_rd_reg   <= '0;
                        scan_pend_reg <= 1'b0;
                        ge_cnt_reg    <= '0;
                        gt_cnt_reg    <= '0;
                        hit_reg       <= 1'b0;
                        res_ok_reg    <= 1'b0;
                        res_rep_reg   <= 1'b0;
                        unique case (in_data.kind)
                            stsig_pkg::KIND_UPSERT:
                                state_reg <= req_good ? S_SCAN : S_FIN;
                            stsig_pkg::KIND_CLEAR:
                            begin
                                total_reg  <= '0;
                                rev_reg    <= rev_reg + 32'd1;
                                res_ok_reg <= 1'b1;
                                state_reg  <= S_FIN;
                            end
                            stsig_pkg::KIND_READ:
                                state_reg <= S_READ;
                            default:
                                state_reg <= S_SCAN;
                        endcase
                    end
                end

                S_SCAN:
                begin
                    if (scan_rd_reg < total_reg)
                    begin
                        scan_pend_reg <= 1'b1;
                        scan_tag_reg  <= scan_rd_reg;
                        scan_rd_reg   <= scan_rd_reg + 1'b1;
                    end
                    else
                    begin
                        scan_pend_reg <= 1'b0;
                    end

                    if (scan_pend_reg)
                    begin
                        if (d_match && !hit_reg)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= scan_tag_reg;
                            hit_rec_reg <= mem_q;
                            hit_ge_reg  <= ge_cnt_reg;
                            hit_gt_reg  <= gt_cnt_reg + CW'(d_gt);
                        end
                        if (d_older)
                        begin
                            old_idx_reg  <= scan_tag_reg;
                            old_seen_reg <= mem_q.seen;
                            old_ge_reg   <= ge_cnt_reg;
                            old_gt_reg   <= gt_cnt_reg + CW'(d_gt);
                        end
                        ge_cnt_reg <= ge_cnt_reg + CW'(d_ge);
                        gt_cnt_reg <= gt_cnt_reg + CW'(d_gt);
                    end
                    else if (scan_rd_reg == total_reg)
                    begin
                        if (req_reg.kind == stsig_pkg::KIND_FIND)
                        begin
                            res_ok_reg  <= hit_reg;
                            res_rep_reg <= hit_reg;
                            res_idx_reg <= 7'(hit_idx_reg);
                            res_rec_reg <= hit_rec_reg;
                            state_reg   <= S_FIN;
                        end
                        else
                        begin
                            q_reg       <= sel_q;
                            x_reg       <= sel_x;
                            mv_pend_reg <= 1'b0;
                            if (sel_q < sel_p)
                            begin
                                mv_dn_reg   <= 1'b1;
                                mv_left_reg <= sel_p - sel_q;
                                mv_rd_reg   <= sel_p - 1'b1;
                            end
                            else
                            begin
                                mv_dn_reg   <= 1'b0;
                                mv_left_reg <= sel_q - sel_p;
                                mv_rd_reg   <= sel_p + 1'b1;
                            end
                            if (sel_append)
                            begin
                                total_reg <= total_reg + 1'b1;
                            end
                            state_reg <= S_MOVE;
                        end
                    end
                end

                S_MOVE:
                begin
                    if (mv_left_reg != '0)
                    begin
                        mv_pend_reg <= 1'b1;
                        mv_wa_reg   <= mv_dn_reg ? mv_rd_reg + 1'b1 : mv_rd_reg - 1'b1;
                        mv_rd_reg   <= mv_dn_reg ? mv_rd_reg - 1'b1 : mv_rd_reg + 1'b1;
                        mv_left_reg <= mv_left_reg - 1'b1;
                    end
                    else
                    begin
                        mv_pend_reg <= 1'b0;
                        if (!mv_pend_reg)
                        begin
                            state_reg <= S_PUT;
                        end
                    end
                end

                S_PUT:
                begin
                    rev_reg     <= rev_reg + 32'd1;
                    res_ok_reg  <= 1'b1;
                    res_rep_reg <= 1'b1;
                    res_idx_reg <= 7'(q_reg);
                    res_rec_reg <= x_reg;
                    state_reg   <= S_FIN;
                end

                S_READ:
                begin
                    res_ok_reg  <= (7'(req_reg.entry_select) < 7'(total_reg));
                    res_rep_reg <= (7'(req_reg.entry_select) < 7'(total_reg));
                    res_idx_reg <= 7'(req_reg.entry_select);
                    res_rec_reg <= mem_q;
                    state_reg   <= S_FIN;
                end

                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg   <= out_build;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/stsig_ram.sv -----
module stsig_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  stsig_pkg::rec_t      wdata,
    input  logic [AW-1:0]        raddr,
    output stsig_pkg::rec_t      rdata
);

    stsig_pkg::rec_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
